// ===== rtl/dashed_line_segment_generator_defines.svh =====
// Assertion macros shared by the dashed line segment generator modules
`ifndef DASHED_LINE_SEGMENT_GENERATOR_DEFINES_SVH
`define DASHED_LINE_SEGMENT_GENERATOR_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define DLSG_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("dlsg check failed");
`define DLSG_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("dlsg check failed");
`else
`define DLSG_ASSERT_IMPL(label, ante, cons)
`define DLSG_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== rtl/dlsg_pkg.sv =====
// Types, constants and helper functions of the dashed line segment generator
package dlsg_pkg;

	localparam int COORD_WIDTH     = 16;
	localparam int SLOPE_FRAC_BITS = 16;
	localparam int MAX_SEGMENTS    = 64;
	localparam int LEN_WIDTH       = 12;

	localparam int PER_WIDTH       = LEN_WIDTH + 1;
	localparam int DELTA_WIDTH     = COORD_WIDTH + 1;
	localparam int OFF_WIDTH       = COORD_WIDTH + 1;
	localparam int K_WIDTH         = SLOPE_FRAC_BITS + 2;
	localparam int PROD_WIDTH      = OFF_WIDTH + K_WIDTH;
	localparam int SUM_WIDTH       = PROD_WIDTH + 1;
	localparam int SLOPE_NUM_WIDTH = COORD_WIDTH + SLOPE_FRAC_BITS;
	localparam int DIV_STEPS       = (SLOPE_FRAC_BITS + 1 > COORD_WIDTH) ?
		SLOPE_FRAC_BITS + 1 : COORD_WIDTH;
	localparam int DIV_CNT_WIDTH   = $clog2(DIV_STEPS);
	localparam int REM_WIDTH       = ((COORD_WIDTH > PER_WIDTH) ? COORD_WIDTH : PER_WIDTH) + 1;
	localparam int SEG_WIDTH       = $clog2(MAX_SEGMENTS + 1);
	localparam int TOTAL_WIDTH     = COORD_WIDTH + 1;
	localparam int CFG_INDEX_WIDTH = 3;
	localparam int CFG_DATA_WIDTH  = (COORD_WIDTH > LEN_WIDTH) ? COORD_WIDTH : LEN_WIDTH;

	localparam logic [CFG_INDEX_WIDTH-1:0] CFG_DASH        = CFG_INDEX_WIDTH'(0);
	localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SPACE       = CFG_INDEX_WIDTH'(1);
	localparam logic [CFG_INDEX_WIDTH-1:0] CFG_CLIP_LEFT   = CFG_INDEX_WIDTH'(2);
	localparam logic [CFG_INDEX_WIDTH-1:0] CFG_CLIP_TOP    = CFG_INDEX_WIDTH'(3);
	localparam logic [CFG_INDEX_WIDTH-1:0] CFG_CLIP_RIGHT  = CFG_INDEX_WIDTH'(4);
	localparam logic [CFG_INDEX_WIDTH-1:0] CFG_CLIP_BOTTOM = CFG_INDEX_WIDTH'(5);

	localparam logic [LEN_WIDTH-1:0]   DASH_RESET        = LEN_WIDTH'(4);
	localparam logic [LEN_WIDTH-1:0]   SPACE_RESET       = LEN_WIDTH'(4);
	localparam logic [COORD_WIDTH-1:0] CLIP_LEFT_RESET   = COORD_WIDTH'(0);
	localparam logic [COORD_WIDTH-1:0] CLIP_TOP_RESET    = COORD_WIDTH'(0);
	localparam logic [COORD_WIDTH-1:0] CLIP_RIGHT_RESET  = COORD_WIDTH'(4096);
	localparam logic [COORD_WIDTH-1:0] CLIP_BOTTOM_RESET = COORD_WIDTH'(4096);

	localparam logic [1:0] KIND_DASH  = 2'd0;
	localparam logic [1:0] KIND_SOLID = 2'd1;
	localparam logic [1:0] KIND_POINT = 2'd2;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] start_x;
		logic signed [COORD_WIDTH-1:0] start_y;
		logic signed [COORD_WIDTH-1:0] end_x;
		logic signed [COORD_WIDTH-1:0] end_y;
	} item_t;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] from_x;
		logic signed [COORD_WIDTH-1:0] from_y;
		logic signed [COORD_WIDTH-1:0] to_x;
		logic signed [COORD_WIDTH-1:0] to_y;
		logic [1:0]                    seg_kind;
		logic                          last_segment;
		logic                          truncated;
	} result_t;

	typedef struct packed {
		logic accept;
		logic prep;
		logic fin;
		logic emit;
		logic solo;
	} ctrl_cmd_t;

	typedef struct packed {
		logic drop;
		logic solid;
		logic point;
		logic div_busy;
		logic seg_last;
		logic pipe_busy;
	} ctrl_stat_t;

	// one restoring step: returns {next remainder, quotient bit}
	function automatic logic [REM_WIDTH:0] div_step(
		input logic [REM_WIDTH-1:0] rem,
		input logic                 bit_in,
		input logic [REM_WIDTH-1:0] den
	);
		logic [REM_WIDTH-1:0] trial;
		trial = {rem[REM_WIDTH-2:0], bit_in};
		if (trial >= den) begin
			return {trial - den, 1'b1};
		end
		return {trial, 1'b0};
	endfunction

endpackage

// ===== rtl/dlsg_div.sv =====
// Dual-lane restoring divider: slope quotient and dash period quotient/remainder
module dlsg_div (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    load,
	input  logic [dlsg_pkg::SLOPE_NUM_WIDTH-1:0]    slope_num,
	input  logic [dlsg_pkg::COORD_WIDTH-1:0]        slope_den,
	input  logic [dlsg_pkg::COORD_WIDTH-1:0]        per_num,
	input  logic [dlsg_pkg::PER_WIDTH-1:0]          per_den,
	output logic                                    busy,
	output logic [dlsg_pkg::DIV_STEPS-1:0]          slope_quot,
	output logic [dlsg_pkg::DIV_STEPS-1:0]          per_quot,
	output logic [dlsg_pkg::REM_WIDTH-1:0]          per_rem
);
	import dlsg_pkg::*;

	logic [REM_WIDTH-1:0]     s_rem_q, p_rem_q, s_den_q, p_den_q;
	logic [DIV_STEPS-1:0]     s_sh_q, p_sh_q;
	logic [DIV_CNT_WIDTH-1:0] cnt_q;
	logic                     run_q;
	logic [REM_WIDTH:0]       s_nx, p_nx;

	always_comb begin
		s_nx = div_step(s_rem_q, s_sh_q[DIV_STEPS-1], s_den_q);
		p_nx = div_step(p_rem_q, p_sh_q[DIV_STEPS-1], p_den_q);
	end

	always_ff @(posedge clk) begin
		if (load) begin
			s_rem_q <= REM_WIDTH'(slope_num >> DIV_STEPS);
			s_sh_q  <= slope_num[DIV_STEPS-1:0];
			s_den_q <= REM_WIDTH'(slope_den);
			p_rem_q <= REM_WIDTH'(per_num >> DIV_STEPS);
			p_sh_q  <= DIV_STEPS'(per_num);
			p_den_q <= REM_WIDTH'(per_den);
		end else if (run_q) begin
			s_rem_q <= s_nx[REM_WIDTH:1];
			s_sh_q  <= {s_sh_q[DIV_STEPS-2:0], s_nx[0]};
			p_rem_q <= p_nx[REM_WIDTH:1];
			p_sh_q  <= {p_sh_q[DIV_STEPS-2:0], p_nx[0]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
		end else if (load) begin
			run_q <= 1'b1;
			cnt_q <= '0;
		end else if (run_q) begin
			if (cnt_q == DIV_CNT_WIDTH'(DIV_STEPS - 1)) begin
				run_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q + DIV_CNT_WIDTH'(1);
			end
		end
	end

	assign busy       = run_q;
	assign slope_quot = s_sh_q;
	assign per_quot   = p_sh_q;
	assign per_rem    = p_rem_q;

endmodule

// ===== rtl/dlsg_ctrl.sv =====
// Controller state machine of the dashed line segment generator
`include "dashed_line_segment_generator_defines.svh"
module dlsg_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  dlsg_pkg::ctrl_stat_t   stat,
	output dlsg_pkg::ctrl_cmd_t    cmd
);
	import dlsg_pkg::*;

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_CHECK = 8'b0000_0010,
		S_PREP  = 8'b0000_0100,
		S_DIV   = 8'b0000_1000,
		S_FIN   = 8'b0001_0000,
		S_EMIT  = 8'b0010_0000,
		S_SOLO  = 8'b0100_0000,
		S_DRAIN = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				if (stat.drop) begin
					state_d = S_IDLE;
				end else if (stat.solid || stat.point) begin
					state_d = S_SOLO;
				end else begin
					state_d = S_PREP;
				end
			end
			S_PREP: state_d = S_DIV;
			S_DIV: begin
				if (!stat.div_busy) begin
					state_d = S_FIN;
				end
			end
			S_FIN: state_d = S_EMIT;
			S_EMIT: begin
				if (stat.seg_last) begin
					state_d = S_DRAIN;
				end
			end
			S_SOLO: state_d = S_DRAIN;
			S_DRAIN: begin
				if (!stat.pipe_busy) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		cmd.accept = (state_q == S_IDLE) && start;
		cmd.prep   = (state_q == S_PREP);
		cmd.fin    = (state_q == S_FIN);
		cmd.emit   = (state_q == S_EMIT);
		cmd.solo   = (state_q == S_SOLO);
	end

	assign busy = (state_q != S_IDLE);

	`DLSG_ASSERT_IMPL(a_fin_after_div, state_q == S_FIN, !stat.div_busy)
	`DLSG_ASSERT_IMPL(a_idle_pipe_empty, state_q == S_IDLE, !stat.pipe_busy)
	`DLSG_ASSERT_NEXT(a_emit_holds, state_q == S_EMIT && !stat.seg_last, busy)

endmodule

// ===== rtl/dlsg_dp.sv =====
// Datapath: configuration, line setup, divider and segment pipeline
`include "dashed_line_segment_generator_defines.svh"
module dlsg_dp (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_valid,
	input  logic [dlsg_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
	input  logic [dlsg_pkg::CFG_DATA_WIDTH-1:0]   cfg_data,
	input  dlsg_pkg::item_t                       item,
	input  dlsg_pkg::ctrl_cmd_t                   cmd,
	output dlsg_pkg::ctrl_stat_t                  stat,
	output dlsg_pkg::result_t                     result,
	output logic                                  result_valid
);
	import dlsg_pkg::*;

	localparam logic [SUM_WIDTH-1:0] TRUNC_BIAS = SUM_WIDTH'((1 << SLOPE_FRAC_BITS) - 1);

	logic [LEN_WIDTH-1:0]          dash_q, space_q;
	logic signed [COORD_WIDTH-1:0] clip_left_q, clip_top_q, clip_right_q, clip_bottom_q;

	item_t                         in_q;
	logic signed [COORD_WIDTH-1:0] x1, y1, x2, y2;
	logic signed [DELTA_WIDTH-1:0] dx_q, dy_q, rx, ry;
	logic [COORD_WIDTH-1:0]        rx_u, ry_u, rmaj, rmin;
	logic                          xmaj, drop, solid, point;
	logic [PER_WIDTH-1:0]          period;

	logic                          xmaj_q, s_neg_q, k_neg_q;
	logic                          div_busy;
	logic [DIV_STEPS-1:0]          slope_quot, per_quot;
	logic [REM_WIDTH-1:0]          per_rem;

	logic signed [K_WIDTH-1:0]     k_mag, k_q;
	logic [COORD_WIDTH-1:0]        n_q;
	logic [LEN_WIDTH-1:0]          frec, frec_q;
	logic [TOTAL_WIDTH-1:0]        total;
	logic [SEG_WIDTH-1:0]          emit_q, seg_q;
	logic                          trunc_q;
	logic [COORD_WIDTH-1:0]        pos_q, mag_b;
	logic [LEN_WIDTH-1:0]          len;
	logic signed [OFF_WIDTH-1:0]   mag_a_s, mag_b_s;

	logic                          valid_s1, valid_s2, res_valid_q;
	logic                          last_s1, last_s2;
	logic signed [OFF_WIDTH-1:0]   off_a_s1, off_b_s1;
	logic signed [COORD_WIDTH-1:0] maj_start, min_start;
	logic signed [PROD_WIDTH-1:0]  prod_a, prod_b;
	logic [COORD_WIDTH-1:0]        maj_a_s2, maj_b_s2;
	logic signed [SUM_WIDTH-1:0]   sum_a_s2, sum_b_s2;
	logic [SUM_WIDTH-1:0]          adj_a, adj_b;
	logic [COORD_WIDTH-1:0]        min_a, min_b;
	result_t                       res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dash_q        <= DASH_RESET;
			space_q       <= SPACE_RESET;
			clip_left_q   <= CLIP_LEFT_RESET;
			clip_top_q    <= CLIP_TOP_RESET;
			clip_right_q  <= CLIP_RIGHT_RESET;
			clip_bottom_q <= CLIP_BOTTOM_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_DASH:        dash_q        <= cfg_data[LEN_WIDTH-1:0];
				CFG_SPACE:       space_q       <= cfg_data[LEN_WIDTH-1:0];
				CFG_CLIP_LEFT:   clip_left_q   <= cfg_data[COORD_WIDTH-1:0];
				CFG_CLIP_TOP:    clip_top_q    <= cfg_data[COORD_WIDTH-1:0];
				CFG_CLIP_RIGHT:  clip_right_q  <= cfg_data[COORD_WIDTH-1:0];
				CFG_CLIP_BOTTOM: clip_bottom_q <= cfg_data[COORD_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			in_q <= item;
		end
		dx_q <= DELTA_WIDTH'(x2) - DELTA_WIDTH'(x1);
		dy_q <= DELTA_WIDTH'(y2) - DELTA_WIDTH'(y1);
	end

	assign x1 = in_q.start_x;
	assign y1 = in_q.start_y;
	assign x2 = in_q.end_x;
	assign y2 = in_q.end_y;

	always_comb begin
		drop = (dash_q == '0) ||
			(x1 < clip_left_q && x2 < clip_left_q) ||
			(x1 >= clip_right_q && x2 >= clip_right_q) ||
			(y1 < clip_top_q && y2 < clip_top_q) ||
			(y1 >= clip_bottom_q && y2 >= clip_bottom_q);
		solid = (space_q == '0);
		point = (x1 == x2) && (y1 == y2);
	end

	always_comb begin
		rx     = dx_q[DELTA_WIDTH-1] ? -dx_q : dx_q;
		ry     = dy_q[DELTA_WIDTH-1] ? -dy_q : dy_q;
		rx_u   = rx[COORD_WIDTH-1:0];
		ry_u   = ry[COORD_WIDTH-1:0];
		xmaj   = rx_u > ry_u;
		rmaj   = xmaj ? rx_u : ry_u;
		rmin   = xmaj ? ry_u : rx_u;
		period = PER_WIDTH'(dash_q) + PER_WIDTH'(space_q);
	end

	always_ff @(posedge clk) begin
		if (cmd.prep) begin
			xmaj_q  <= xmaj;
			s_neg_q <= xmaj ? dx_q[DELTA_WIDTH-1] : dy_q[DELTA_WIDTH-1];
			k_neg_q <= dx_q[DELTA_WIDTH-1] ^ dy_q[DELTA_WIDTH-1];
		end
	end

	dlsg_div u_div (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (cmd.prep),
		.slope_num  ({rmin, {SLOPE_FRAC_BITS{1'b0}}}),
		.slope_den  (rmaj),
		.per_num    (rmaj),
		.per_den    (period),
		.busy       (div_busy),
		.slope_quot (slope_quot),
		.per_quot   (per_quot),
		.per_rem    (per_rem)
	);

	always_comb begin
		k_mag = {1'b0, slope_quot[SLOPE_FRAC_BITS:0]};
		frec  = (per_rem > REM_WIDTH'(dash_q)) ? dash_q : per_rem[LEN_WIDTH-1:0];
		total = TOTAL_WIDTH'(per_quot[COORD_WIDTH-1:0]) + TOTAL_WIDTH'(frec != '0);
	end

	always_ff @(posedge clk) begin
		if (cmd.fin) begin
			k_q     <= k_neg_q ? -k_mag : k_mag;
			n_q     <= per_quot[COORD_WIDTH-1:0];
			frec_q  <= frec;
			trunc_q <= total > TOTAL_WIDTH'(MAX_SEGMENTS);
			emit_q  <= (total > TOTAL_WIDTH'(MAX_SEGMENTS)) ?
				SEG_WIDTH'(MAX_SEGMENTS) : total[SEG_WIDTH-1:0];
			seg_q   <= '0;
			pos_q   <= '0;
		end else if (cmd.emit) begin
			seg_q   <= seg_q + SEG_WIDTH'(1);
			pos_q   <= pos_q + COORD_WIDTH'(period);
		end
	end

	always_comb begin
		len     = (TOTAL_WIDTH'(seg_q) < TOTAL_WIDTH'(n_q)) ? dash_q : frec_q;
		mag_b   = pos_q + COORD_WIDTH'(len);
		mag_a_s = {1'b0, pos_q};
		mag_b_s = {1'b0, mag_b};
	end

	always_ff @(posedge clk) begin
		off_a_s1 <= s_neg_q ? -mag_a_s : mag_a_s;
		off_b_s1 <= s_neg_q ? -mag_b_s : mag_b_s;
		last_s1  <= (seg_q == emit_q - SEG_WIDTH'(1));
	end

	always_comb begin
		maj_start = xmaj_q ? x1 : y1;
		min_start = xmaj_q ? y1 : x1;
	end

	assign prod_a = off_a_s1 * k_q;
	assign prod_b = off_b_s1 * k_q;

	always_ff @(posedge clk) begin
		maj_a_s2 <= maj_start + off_a_s1[COORD_WIDTH-1:0];
		maj_b_s2 <= maj_start + off_b_s1[COORD_WIDTH-1:0];
		sum_a_s2 <= (SUM_WIDTH'(min_start) <<< SLOPE_FRAC_BITS) + SUM_WIDTH'(prod_a);
		sum_b_s2 <= (SUM_WIDTH'(min_start) <<< SLOPE_FRAC_BITS) + SUM_WIDTH'(prod_b);
		last_s2  <= last_s1;
	end

	always_comb begin
		adj_a = sum_a_s2 + (sum_a_s2[SUM_WIDTH-1] ? TRUNC_BIAS : '0);
		adj_b = sum_b_s2 + (sum_b_s2[SUM_WIDTH-1] ? TRUNC_BIAS : '0);
		min_a = adj_a[SLOPE_FRAC_BITS +: COORD_WIDTH];
		min_b = adj_b[SLOPE_FRAC_BITS +: COORD_WIDTH];
	end

	always_ff @(posedge clk) begin
		if (valid_s2) begin
			res_q.from_x       <= xmaj_q ? maj_a_s2 : min_a;
			res_q.from_y       <= xmaj_q ? min_a : maj_a_s2;
			res_q.to_x         <= xmaj_q ? maj_b_s2 : min_b;
			res_q.to_y         <= xmaj_q ? min_b : maj_b_s2;
			res_q.seg_kind     <= KIND_DASH;
			res_q.last_segment <= last_s2;
			res_q.truncated    <= trunc_q;
		end else if (cmd.solo) begin
			res_q.from_x       <= x1;
			res_q.from_y       <= y1;
			res_q.to_x         <= solid ? x2 : x1;
			res_q.to_y         <= solid ? y2 : y1;
			res_q.seg_kind     <= solid ? KIND_SOLID : KIND_POINT;
			res_q.last_segment <= 1'b1;
			res_q.truncated    <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			valid_s1    <= cmd.emit;
			valid_s2    <= valid_s1;
			res_valid_q <= valid_s2 || cmd.solo;
		end
	end

	always_comb begin
		stat.drop      = drop;
		stat.solid     = solid;
		stat.point     = point;
		stat.div_busy  = div_busy;
		stat.seg_last  = (seg_q == emit_q - SEG_WIDTH'(1));
		stat.pipe_busy = valid_s1 || valid_s2 || res_valid_q;
	end

	assign result       = res_q;
	assign result_valid = res_valid_q;

	`DLSG_ASSERT_NEXT(a_last_ends_burst, res_valid_q && res_q.last_segment, !res_valid_q)
	`DLSG_ASSERT_IMPL(a_single_is_last, res_valid_q && res_q.seg_kind != KIND_DASH, res_q.last_segment)
	`DLSG_ASSERT_IMPL(a_trunc_only_dash, res_valid_q && res_q.truncated, res_q.seg_kind == KIND_DASH)

endmodule

// ===== rtl/dashed_line_segment_generator.sv =====
// Dashed line segment generator: cuts one line into dash segments
// A dashed line holds busy through check, load, 17 divider steps, setup, then one segment per
// cycle through a 3-stage pipeline, then a drain. A zero dash length, or both ends beyond one
// clip edge, drops the line with no result; solid and single-pixel lines skip the divider and
// give one result. Results strobe one cycle each, no stall; async active-low reset idles
// control, clears the valid flags and restores the configuration defaults.
module dashed_line_segment_generator (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	output logic                                  busy,
	input  dlsg_pkg::item_t                       item,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [dlsg_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
	input  logic [dlsg_pkg::CFG_DATA_WIDTH-1:0]   cfg_data,
	output dlsg_pkg::result_t                     result,
	output logic                                  result_valid
);
	import dlsg_pkg::*;

	ctrl_cmd_t  cmd;
	ctrl_stat_t stat;

	assign cfg_ready = 1'b1;

	dlsg_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.stat   (stat),
		.cmd    (cmd)
	);

	dlsg_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.item         (item),
		.cmd          (cmd),
		.stat         (stat),
		.result       (result),
		.result_valid (result_valid)
	);

endmodule
